/* hdl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the transition sampler
// Field widths, operation codes and default table size.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int CH_BITS       = 4;
	localparam int COUNT_BITS    = 32;
	localparam int FRACTION_BITS = 16;
	localparam int OP_BITS       = 2;
	localparam int ROWS_DEF      = 16;
	localparam int COLS_DEF      = 16;

	localparam int S_TDATA_BITS  = CH_BITS + CH_BITS + COUNT_BITS + FRACTION_BITS;
	localparam int M_TDATA_BITS  = 8;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD     = 2'd0,
		OP_REBUILD = 2'd1,
		OP_SAMPLE  = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

endpackage

/* hdl/mts_alu.sv */
// ----------------------------------------------------------------------------
// mts_alu: shared count arithmetic
// Saturating add of two counts and an unsigned greater-or-equal compare.
// ----------------------------------------------------------------------------
module mts_alu (
	input  logic [mts_pkg::COUNT_BITS-1:0] a,
	input  logic [mts_pkg::COUNT_BITS-1:0] b,
	output logic [mts_pkg::COUNT_BITS-1:0] sat_sum,
	output logic                           ge
);
	import mts_pkg::*;

	logic [COUNT_BITS:0] sum;

	always_comb begin
		sum     = {1'b0, a} + {1'b0, b};
		sat_sum = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
		ge      = (a >= b);
	end

endmodule

/* hdl/markov_transition_sampler.sv */
// ----------------------------------------------------------------------------
// markov_transition_sampler: sparse transition count table with sampling
// Accumulates counts, rebuilds running sums, draws the next channel.
// ----------------------------------------------------------------------------
// Input words arrive on s_*, one result word per input word leaves on m_*.
// s_tuser carries the operation (add, rebuild, sample, no operation);
// s_tdata carries from_channel, to_channel, count and uniform.
// m_tdata carries next_channel, m_tuser carries found.
// After reset a clearing pass walks every table address, one per cycle
// (2^(clog2(ROWS)+clog2(COLS)) addresses, 256 at the default size); s_tready
// stays low until it ends.
// One word is worked on at a time; s_tready is high only while idle.
// States from acceptance to m_tvalid use one shared adder/compare unit and
// memories with one write port and a registered read port each. add: read
// the cell, write the sum; sample: read total and length, multiply, form the
// threshold, compare list entries in turn; rebuild: per row read length, per
// entry read order and cell, add; no operation, out-of-range input: result.
// A result waits in the output register while m_tready is low; the next
// word is still accepted and runs up to its own result, then holds.
// ----------------------------------------------------------------------------
module markov_transition_sampler #(
	parameter int ROWS = mts_pkg::ROWS_DEF,
	parameter int COLS = mts_pkg::COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// from_channel[3:0], to_channel[7:4], count[39:8], uniform[55:40]
	input  logic [mts_pkg::S_TDATA_BITS-1:0] s_tdata,
	// operation[1:0]
	input  logic [mts_pkg::OP_BITS-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// next_channel[3:0], zero[7:4]
	output logic [mts_pkg::M_TDATA_BITS-1:0] m_tdata,
	// found[0]
	output logic [0:0]                       m_tuser
);
	import mts_pkg::*;

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int LW    = $clog2(COLS + 1);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int RDEP  = 1 << RW;
	localparam int PW    = FRACTION_BITS + COUNT_BITS;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WR,
		ST_RB_LEN, ST_RB_LENW, ST_RB_ORD, ST_RB_CELL, ST_RB_ACC,
		ST_SM_RD, ST_SM_MUL, ST_SM_THR, ST_SM_SCAN, ST_SM_CMP,
		ST_RESP
	} state_t;

	state_t                   state_q;
	logic [AW-1:0]            clr_q;
	logic [RW-1:0]            row_q;
	logic [CW-1:0]            col_q;
	logic [COUNT_BITS-1:0]    cnt_q;
	logic [FRACTION_BITS-1:0] uni_q;
	logic [LW-1:0]            k_q;
	logic [LW-1:0]            len_q;
	logic [COUNT_BITS-1:0]    acc_q;
	logic [PW-1:0]            prod_q;
	logic [COUNT_BITS-1:0]    thr_q;
	logic [CH_BITS-1:0]       res_ch_q;
	logic                     res_found_q;
	logic                     out_valid_q;
	logic [CH_BITS-1:0]       out_ch_q;
	logic                     out_found_q;

	logic [COUNT_BITS-1:0]    cell_mem [DEPTH];
	logic [CW-1:0]            order_mem [DEPTH];
	logic [COUNT_BITS-1:0]    sum_mem [DEPTH];
	logic [LW-1:0]            len_mem [RDEP];
	logic [COUNT_BITS-1:0]    tot_mem [RDEP];

	logic [COUNT_BITS-1:0]    cell_rd_q;
	logic [CW-1:0]            order_rd_q;
	logic [COUNT_BITS-1:0]    sum_rd_q;
	logic [LW-1:0]            len_rd_q;
	logic [COUNT_BITS-1:0]    tot_rd_q;

	logic [AW-1:0]            cell_ra, cell_wa, sum_wa, kaddr;
	logic [RW-1:0]            len_wa, tot_wa;
	logic                     cell_we, order_we, sum_we, len_we, tot_we;
	logic [COUNT_BITS-1:0]    cell_wd, sum_wd, tot_wd;
	logic [LW-1:0]            len_wd;
	logic [AW-1:0]            order_wa;

	logic [COUNT_BITS-1:0]    alu_a, alu_b, alu_sum;
	logic                     alu_ge;

	logic [CH_BITS-1:0]       in_from, in_to;
	logic [COUNT_BITS-1:0]    in_cnt;
	logic [FRACTION_BITS-1:0] in_uni;
	op_t                      in_op;
	logic                     clr_col0;
	logic                     last_k;

	assign in_from = s_tdata[CH_BITS-1:0];
	assign in_to   = s_tdata[2*CH_BITS-1:CH_BITS];
	assign in_cnt  = s_tdata[2*CH_BITS +: COUNT_BITS];
	assign in_uni  = s_tdata[2*CH_BITS+COUNT_BITS +: FRACTION_BITS];
	assign in_op   = op_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_BITS'(out_ch_q);
	assign m_tuser  = out_found_q;

	assign kaddr    = {row_q, k_q[CW-1:0]};
	assign clr_col0 = (clr_q[CW-1:0] == '0);
	assign last_k   = ((k_q + LW'(1)) == len_q);

	mts_alu u_alu (
		.a       (alu_a),
		.b       (alu_b),
		.sat_sum (alu_sum),
		.ge      (alu_ge)
	);

	always_comb begin
		alu_a = acc_q;
		alu_b = cell_rd_q;
		case (state_q)
			ST_ADD_WR: begin
				alu_a = cell_rd_q;
				alu_b = cnt_q;
			end
			ST_SM_CMP: begin
				alu_a = sum_rd_q;
				alu_b = thr_q;
			end
			default: begin
				alu_a = acc_q;
				alu_b = cell_rd_q;
			end
		endcase
	end

	always_comb begin
		cell_ra  = (state_q == ST_RB_CELL) ? {row_q, order_rd_q} : {row_q, col_q};
		cell_we  = 1'b0;
		cell_wa  = {row_q, col_q};
		cell_wd  = alu_sum;
		order_we = 1'b0;
		order_wa = {row_q, len_rd_q[CW-1:0]};
		sum_we   = 1'b0;
		sum_wa   = kaddr;
		sum_wd   = alu_sum;
		len_we   = 1'b0;
		len_wa   = row_q;
		len_wd   = len_rd_q + LW'(1);
		tot_we   = 1'b0;
		tot_wa   = row_q;
		tot_wd   = alu_sum;
		case (state_q)
			ST_CLEAR: begin
				cell_we = 1'b1;
				cell_wa = clr_q;
				cell_wd = '0;
				sum_we  = 1'b1;
				sum_wa  = clr_q;
				sum_wd  = '0;
				len_we  = clr_col0;
				len_wa  = clr_q[AW-1:CW];
				len_wd  = '0;
				tot_we  = clr_col0;
				tot_wa  = clr_q[AW-1:CW];
				tot_wd  = '0;
			end
			ST_ADD_WR: begin
				if (cell_rd_q != '0 || len_rd_q < LW'(COLS)) begin
					cell_we = 1'b1;
				end
				if (cell_rd_q == '0 && len_rd_q < LW'(COLS)) begin
					order_we = 1'b1;
					len_we   = 1'b1;
				end
			end
			ST_RB_ACC: begin
				sum_we = 1'b1;
				tot_we = last_k;
			end
			default: begin
				cell_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		cell_rd_q <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[order_wa] <= col_q;
		end
		order_rd_q <= order_mem[kaddr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		sum_rd_q <= sum_mem[kaddr];
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_wa] <= len_wd;
		end
		len_rd_q <= len_mem[row_q];
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_wa] <= tot_wd;
		end
		tot_rd_q <= tot_mem[row_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_ch_q    <= '0;
			out_found_q <= 1'b0;
			res_ch_q    <= '0;
			res_found_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			uni_q       <= '0;
			k_q         <= '0;
			len_q       <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			thr_q       <= '0;
		end else begin
			if (state_q == ST_RESP && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
				out_ch_q    <= res_ch_q;
				out_found_q <= res_found_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						res_ch_q    <= '0;
						res_found_q <= 1'b0;
						row_q       <= RW'(in_from);
						col_q       <= CW'(in_to);
						cnt_q       <= in_cnt;
						uni_q       <= in_uni;
						case (in_op)
							OP_ADD: begin
								if (32'(in_from) >= ROWS || 32'(in_to) >= COLS ||
								    in_cnt == '0) begin
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_ADD_RD;
								end
							end
							OP_REBUILD: begin
								row_q   <= '0;
								state_q <= ST_RB_LEN;
							end
							OP_SAMPLE: begin
								if (32'(in_from) >= ROWS) begin
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_SM_RD;
								end
							end
							OP_NOP:  state_q <= ST_RESP;
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: state_q <= ST_RESP;
				ST_RB_LEN: state_q <= ST_RB_LENW;
				ST_RB_LENW: begin
					if (len_rd_q == '0) begin
						if (row_q == RW'(ROWS - 1)) begin
							state_q <= ST_RESP;
						end else begin
							row_q   <= row_q + RW'(1);
							state_q <= ST_RB_LEN;
						end
					end else begin
						len_q   <= len_rd_q;
						k_q     <= '0;
						acc_q   <= '0;
						state_q <= ST_RB_ORD;
					end
				end
				ST_RB_ORD:  state_q <= ST_RB_CELL;
				ST_RB_CELL: state_q <= ST_RB_ACC;
				ST_RB_ACC: begin
					acc_q <= alu_sum;
					if (last_k) begin
						if (row_q == RW'(ROWS - 1)) begin
							state_q <= ST_RESP;
						end else begin
							row_q   <= row_q + RW'(1);
							state_q <= ST_RB_LEN;
						end
					end else begin
						k_q     <= k_q + LW'(1);
						state_q <= ST_RB_ORD;
					end
				end
				ST_SM_RD: state_q <= ST_SM_MUL;
				ST_SM_MUL: begin
					prod_q  <= PW'(uni_q) * PW'(tot_rd_q);
					len_q   <= len_rd_q;
					k_q     <= '0;
					state_q <= ST_SM_THR;
				end
				ST_SM_THR: begin
					thr_q   <= prod_q[FRACTION_BITS +: COUNT_BITS] + COUNT_BITS'(1);
					state_q <= ST_SM_SCAN;
				end
				ST_SM_SCAN: begin
					if (k_q == len_q) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_SM_CMP;
					end
				end
				ST_SM_CMP: begin
					if (alu_ge) begin
						res_ch_q    <= CH_BITS'(order_rd_q);
						res_found_q <= 1'b1;
						state_q     <= ST_RESP;
					end else begin
						k_q     <= k_q + LW'(1);
						state_q <= ST_SM_SCAN;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/mts_checker.sv */
// ----------------------------------------------------------------------------
// mts_checker: port-level checks for the transition sampler
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [mts_pkg::M_TDATA_BITS-1:0] m_tdata,
	input logic [0:0]                       m_tuser
);
	import mts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("channel nonzero without a match");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

endmodule

bind markov_transition_sampler mts_checker u_mts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
